@@ rtl/rmq_pkg.sv @@
`timescale 1ns / 1ps
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int IN_W      = 16;
    localparam int OUT_W     = 16;
    localparam int TERM_W    = IN_W + 2;
    localparam int DIFF_W    = IN_W + 1;
    localparam int SUM_W     = (TERM_W > FRAC_BITS + 1) ? TERM_W : FRAC_BITS + 2;
    localparam int RAD_W     = SUM_W + FRAC_BITS;
    localparam int SQ_N      = (RAD_W + 1) / 2;
    localparam int SQ_RAD_W  = 2 * SQ_N;
    localparam int SQ_REM_W  = SQ_N + 2;
    localparam int SQ_ST     = (SQ_N + 1) / 2;
    localparam int B_W       = SQ_N - 1;
    localparam int DV_W      = B_W + 1;
    localparam int K_W       = FRAC_BITS;
    localparam int DV_ST     = (K_W + 1) / 2;
    localparam int PROD_W    = DIFF_W + K_W + 1;
    localparam int SH_W      = PROD_W - FRAC_BITS;
    localparam int LINE_N    = SQ_ST + DV_ST;
    localparam int VLD_N     = LINE_N + 4;

    typedef enum logic [1:0] {
        SEL_T0 = 2'd0,
        SEL_T1 = 2'd1,
        SEL_T2 = 2'd2,
        SEL_T3 = 2'd3
    } t_sel;

    typedef struct packed {
        logic signed [IN_W-1:0] mat_e0;
        logic signed [IN_W-1:0] mat_e1;
        logic signed [IN_W-1:0] mat_e2;
        logic signed [IN_W-1:0] mat_e3;
        logic signed [IN_W-1:0] mat_e4;
        logic signed [IN_W-1:0] mat_e5;
        logic signed [IN_W-1:0] mat_e6;
        logic signed [IN_W-1:0] mat_e7;
        logic signed [IN_W-1:0] mat_e8;
    } t_mat;

    typedef struct packed {
        logic signed [OUT_W-1:0] quat_c0;
        logic signed [OUT_W-1:0] quat_c1;
        logic signed [OUT_W-1:0] quat_c2;
        logic signed [OUT_W-1:0] quat_c3;
    } t_quat;

    typedef struct packed {
        t_sel                     sel;
        logic signed [DIFF_W-1:0] diff_a;
        logic signed [DIFF_W-1:0] diff_b;
        logic signed [DIFF_W-1:0] diff_c;
    } t_side;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [SQ_N-1:0]     root;
        logic [SQ_RAD_W-1:0] rad;
    } t_sq_st;

    typedef struct packed {
        logic [DV_W-1:0] rem;
        logic [K_W-1:0]  q;
        logic [B_W-1:0]  b;
    } t_dv_st;

endpackage

@@ rtl/rmq_front.sv @@
`timescale 1ns / 1ps
module rmq_front (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  rmq_pkg::t_mat                   i_mat,
    output logic [rmq_pkg::SQ_RAD_W-1:0]    o_rad,
    output rmq_pkg::t_side                  o_side
);
    import rmq_pkg::*;

    localparam logic [SUM_W-1:0] ONE_SUM = SUM_W'(1) << FRAC_BITS;

    logic signed [TERM_W-1:0] x0, x1, x2, x3, x4, x5, x6, x7, x8;
    logic signed [TERM_W-1:0] r_t0, r_t1, r_t2, r_t3;
    logic signed [DIFF_W-1:0] r_d57m, r_d62m, r_d13m, r_s13, r_s62, r_s57;
    logic signed [TERM_W-1:0] best;
    t_sel                     sel;
    logic [SUM_W-1:0]         sum;
    logic [SQ_RAD_W-1:0]      r_rad;
    t_side                    r_side, n_side;

    assign x0 = TERM_W'(i_mat.mat_e0);
    assign x1 = TERM_W'(i_mat.mat_e1);
    assign x2 = TERM_W'(i_mat.mat_e2);
    assign x3 = TERM_W'(i_mat.mat_e3);
    assign x4 = TERM_W'(i_mat.mat_e4);
    assign x5 = TERM_W'(i_mat.mat_e5);
    assign x6 = TERM_W'(i_mat.mat_e6);
    assign x7 = TERM_W'(i_mat.mat_e7);
    assign x8 = TERM_W'(i_mat.mat_e8);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t0   <= x0 + x4 + x8;
            r_t1   <= x0 - x4 - x8;
            r_t2   <= x4 - x0 - x8;
            r_t3   <= x8 - x0 - x4;
            r_d57m <= DIFF_W'(x5 - x7);
            r_d62m <= DIFF_W'(x6 - x2);
            r_d13m <= DIFF_W'(x1 - x3);
            r_s13  <= DIFF_W'(x1 + x3);
            r_s62  <= DIFF_W'(x6 + x2);
            r_s57  <= DIFF_W'(x5 + x7);
        end
    end

    // ties keep the earlier term
    always_comb begin
        best = r_t0;
        sel  = SEL_T0;
        if (r_t1 > best) begin
            best = r_t1;
            sel  = SEL_T1;
        end
        if (r_t2 > best) begin
            best = r_t2;
            sel  = SEL_T2;
        end
        if (r_t3 > best) begin
            best = r_t3;
            sel  = SEL_T3;
        end
        // best is never negative: the four terms sum to zero
        sum = SUM_W'($unsigned(best)) + ONE_SUM;
        n_side.sel = sel;
        unique case (sel)
            SEL_T0: begin
                n_side.diff_a = r_d57m;
                n_side.diff_b = r_d62m;
                n_side.diff_c = r_d13m;
            end
            SEL_T1: begin
                n_side.diff_a = r_d57m;
                n_side.diff_b = r_s13;
                n_side.diff_c = r_s62;
            end
            SEL_T2: begin
                n_side.diff_a = r_d62m;
                n_side.diff_b = r_s13;
                n_side.diff_c = r_s57;
            end
            SEL_T3: begin
                n_side.diff_a = r_d13m;
                n_side.diff_b = r_s62;
                n_side.diff_c = r_s57;
            end
            default: begin
                n_side.diff_a = r_d57m;
                n_side.diff_b = r_d62m;
                n_side.diff_c = r_d13m;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= SQ_RAD_W'({sum, FRAC_BITS'(0)});
            r_side <= n_side;
        end
    end

    assign o_rad  = r_rad;
    assign o_side = r_side;

endmodule

@@ rtl/rmq_sqrt.sv @@
`timescale 1ns / 1ps
module rmq_sqrt (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [rmq_pkg::SQ_RAD_W-1:0]  i_rad,
    output logic [rmq_pkg::SQ_N-1:0]      o_root
);
    import rmq_pkg::*;

    t_sq_st r_st [SQ_ST];
    t_sq_st w_in [SQ_ST];

    assign w_in[0] = '{rem: '0, root: '0, rad: i_rad};

    for (genvar s = 0; s < SQ_ST; s++) begin : g_stage
        t_sq_st              n_st;
        logic [SQ_REM_W-1:0] trial;

        if (s > 0) begin : g_link
            assign w_in[s] = r_st[s-1];
        end

        // two root digits per stage
        always_comb begin
            n_st  = w_in[s];
            trial = '0;
            for (int j = 0; j < 2; j++) begin
                if (2 * s + j < SQ_N) begin
                    n_st.rem = {n_st.rem[SQ_REM_W-3:0], n_st.rad[SQ_RAD_W-1 -: 2]};
                    n_st.rad = {n_st.rad[SQ_RAD_W-3:0], 2'b00};
                    trial    = {n_st.root, 2'b01};
                    if (n_st.rem >= trial) begin
                        n_st.rem  = n_st.rem - trial;
                        n_st.root = {n_st.root[SQ_N-2:0], 1'b1};
                    end else begin
                        n_st.root = {n_st.root[SQ_N-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= n_st;
            end
        end
    end

    assign o_root = r_st[SQ_ST-1].root;

endmodule

@@ rtl/rmq_div.sv @@
`timescale 1ns / 1ps
module rmq_div (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [rmq_pkg::B_W-1:0]   i_b,
    output logic [rmq_pkg::K_W-1:0]   o_k,
    output logic [rmq_pkg::B_W-1:0]   o_b
);
    import rmq_pkg::*;

    // b is at least half of one, so the high part of the dividend is below b
    localparam logic [DV_W-1:0] REM_INIT = DV_W'(1) << (FRAC_BITS - 2);

    t_dv_st r_st [DV_ST];
    t_dv_st w_in [DV_ST];

    assign w_in[0] = '{rem: REM_INIT, q: '0, b: i_b};

    for (genvar s = 0; s < DV_ST; s++) begin : g_stage
        t_dv_st n_st;

        if (s > 0) begin : g_link
            assign w_in[s] = r_st[s-1];
        end

        always_comb begin
            n_st = w_in[s];
            for (int j = 0; j < 2; j++) begin
                if (2 * s + j < K_W) begin
                    n_st.rem = {n_st.rem[DV_W-2:0], 1'b0};
                    if (n_st.rem >= {1'b0, n_st.b}) begin
                        n_st.rem = n_st.rem - {1'b0, n_st.b};
                        n_st.q   = {n_st.q[K_W-2:0], 1'b1};
                    end else begin
                        n_st.q   = {n_st.q[K_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[s] <= n_st;
            end
        end
    end

    assign o_k = r_st[DV_ST-1].q;
    assign o_b = r_st[DV_ST-1].b;

endmodule

@@ rtl/rmq_back.sv @@
`timescale 1ns / 1ps
module rmq_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_vld,
    input  logic [rmq_pkg::K_W-1:0]  i_k,
    input  logic [rmq_pkg::B_W-1:0]  i_b,
    input  rmq_pkg::t_side           i_side,
    output rmq_pkg::t_quat           o_quat
);
    import rmq_pkg::*;

    localparam logic [B_W-1:0]     B_MIN = B_W'(1) << (FRAC_BITS - 1);
    localparam logic [K_W+B_W-1:0] K_NUM = (K_W + B_W)'(1) << (2 * FRAC_BITS - 2);

    logic signed [PROD_W-1:0] r_pa, r_pb, r_pc;
    logic [B_W-1:0]           r_b;
    t_sel                     r_sel;
    logic signed [OUT_W-1:0]  qa, qb, qc, qw;
    t_quat                    n_quat, r_quat;

    function automatic logic signed [OUT_W-1:0] sat(input logic signed [PROD_W-1:0] p);
        logic signed [SH_W-1:0] v;
        v = SH_W'(p >>> FRAC_BITS);
        if (v > SH_W'(32767)) begin
            sat = 16'sd32767;
        end else if (v < -SH_W'(32768)) begin
            sat = -16'sd32768;
        end else begin
            sat = OUT_W'(v);
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa  <= PROD_W'(i_side.diff_a) * $signed({1'b0, i_k});
            r_pb  <= PROD_W'(i_side.diff_b) * $signed({1'b0, i_k});
            r_pc  <= PROD_W'(i_side.diff_c) * $signed({1'b0, i_k});
            r_b   <= i_b;
            r_sel <= i_side.sel;
        end
    end

    assign qa = sat(r_pa);
    assign qb = sat(r_pb);
    assign qc = sat(r_pc);
    assign qw = OUT_W'(r_b);

    always_comb begin
        unique case (r_sel)
            SEL_T0:  n_quat = '{quat_c0: qw, quat_c1: qa, quat_c2: qb, quat_c3: qc};
            SEL_T1:  n_quat = '{quat_c0: qa, quat_c1: qw, quat_c2: qb, quat_c3: qc};
            SEL_T2:  n_quat = '{quat_c0: qa, quat_c1: qb, quat_c2: qw, quat_c3: qc};
            SEL_T3:  n_quat = '{quat_c0: qa, quat_c1: qb, quat_c2: qc, quat_c3: qw};
            default: n_quat = '{quat_c0: qw, quat_c1: qa, quat_c2: qb, quat_c3: qc};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quat <= n_quat;
        end
    end

    assign o_quat = r_quat;

    a_b_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld |-> (i_b >= B_MIN) && (i_k != '0))
        else $error("root below half of one or zero reciprocal");

    a_k_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld |-> ((K_W + B_W)'(i_k) * (K_W + B_W)'(i_b) <= K_NUM)
               && ((K_W + B_W)'(i_k + 1'b1) * (K_W + B_W)'(i_b) > K_NUM))
        else $error("reciprocal is not the floor quotient");

endmodule

@@ rtl/rotation_matrix_to_quaternion_top.sv @@
`timescale 1ns / 1ps
// Rotation matrix to quaternion, Q2.14 fixed point.
// Input channel: i_valid / o_ready with i_mat, nine signed matrix entries.
// Output channel: o_valid / i_ready with o_quat, four signed components.
// One item per cycle is taken while the output side keeps up; every item
// yields exactly one result, in order.
// At 14 fraction bits the pipeline has two front stages (terms, pick
// of the largest), eight square root stages at two root digits each,
// seven reciprocal divider stages at two quotient bits each, one
// multiplier stage and one output stage.
// All stages move together on one enable; o_ready follows the output
// register: when a result waits and i_ready is low the whole pipeline
// holds, and it resumes without losing or repeating an item.
// Reset (synchronous, active low) clears the valid bits of all stages;
// the data registers are not reset.
module rotation_matrix_to_quaternion_top (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rmq_pkg::t_mat   i_mat,
    output logic            o_valid,
    input  logic            i_ready,
    output rmq_pkg::t_quat  o_quat
);
    import rmq_pkg::*;

    logic                en;
    logic [VLD_N-1:0]    r_vld;
    logic [SQ_RAD_W-1:0] rad;
    t_side               side;
    logic [SQ_N-1:0]     root;
    logic [K_W-1:0]      k;
    logic [B_W-1:0]      b;
    t_side               r_line [LINE_N];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[VLD_N-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[VLD_N-2:0], i_valid};
        end
    end

    rmq_front u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_mat  (i_mat),
        .o_rad  (rad),
        .o_side (side)
    );

    rmq_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (rad),
        .o_root (root)
    );

    rmq_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_b   (root[SQ_N-1:1]),
        .o_k   (k),
        .o_b   (b)
    );

    // carry the selection and the off-diagonal terms beside the root and divide
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_line[0] <= side;
            for (int i = 1; i < LINE_N; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    rmq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vld[LINE_N+1]),
        .i_k     (k),
        .i_b     (b),
        .i_side  (r_line[LINE_N-1]),
        .o_quat  (o_quat)
    );

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("item taken while pipeline is stalled");

endmodule
